@@ sv/button_debounce_long_press_core_macros.svh @@
// Assertion macros for the debouncer checker.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BDLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bdlp_pkg.sv @@
// Shared types and constants for the button debouncer.
package bdlp_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MsW      = 16;

  localparam logic [MsW-1:0] HeldMax          = 16'hFFFF;
  localparam logic [MsW-1:0] DebounceReset    = 16'd20;
  localparam logic [MsW-1:0] LongPressReset   = 16'd600;

  // Register index, taken from paddr[2]
  localparam logic RegDebounce  = 1'b0;
  localparam logic RegLongPress = 1'b1;

  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
  } bdlp_cfg_t;

endpackage

@@ sv/bdlp_cfg.sv @@
// APB register file holding the debounce and long-press times.
module bdlp_cfg
  import bdlp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bdlp_cfg_t           cfg_o
);

  bdlp_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  logic      reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegDebounce:  cfg_d.debounce_ms   = pwdata[MsW-1:0];
        RegLongPress: cfg_d.long_press_ms = pwdata[MsW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceReset;
      cfg_q.long_press_ms <= LongPressReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      RegDebounce:  prdata = {16'd0, cfg_q.debounce_ms};
      RegLongPress: prdata = {16'd0, cfg_q.long_press_ms};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/button_debounce_long_press_core.sv @@
// Pipeline: an accepted request is held in the input register, then moves on to the result
// register when the result stage can advance (input register, result register).
// Throughput: one request per cycle while results are taken; the debounce state updates per request.
// An untaken result holds, and the input stage stalls once it holds a request; no bubble on resume.
// Reset (async, active low): valids and debounce state clear, debounce 20 ms, long press 600 ms.
// Configuration takes effect on the next request processed after the write.
module button_debounce_long_press_core
  import bdlp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // poll requests
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // [0] raw_pressed, [32:1] now_ms, [39:33] zero
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata   // [0] stable_pressed, [1] press_pulse,
                                             // [2] release_pulse, [3] long_pulse,
                                             // [19:4] held_ms, [23:20] zero
);

  bdlp_cfg_t cfg;

  bdlp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage
  logic             in_vld_q, in_vld_d;
  logic             in_raw_q;
  logic [TimeW-1:0] in_now_q;
  // result stage
  logic             out_vld_q, out_vld_d;
  logic [23:0]      out_data_q;
  // debounce state
  logic             last_raw_q, last_raw_d;
  logic [TimeW-1:0] chg_time_q, chg_time_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic             long_done_q, long_done_d;
  logic [MsW-1:0]   held_q, held_d;

  logic             adv_out, s_acc, fire;
  logic             raw_chg, settled, press_edge, release_edge, long_fire, long_done_eff;
  logic [TimeW-1:0] chg_time_eff, settle_diff, hold_diff, hold_eff;
  logic [MsW-1:0]   held_sat;

  assign adv_out       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv_out;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign fire          = in_vld_q && adv_out;

  // a raw change restarts the settle window at this poll's time
  assign raw_chg      = in_raw_q != last_raw_q;
  assign chg_time_eff = raw_chg ? in_now_q : chg_time_q;
  assign settle_diff  = in_now_q - chg_time_eff;
  assign settled      = settle_diff >= {16'd0, cfg.debounce_ms};

  assign press_edge   = settled && in_raw_q && !stable_q;
  assign release_edge = settled && !in_raw_q && stable_q;

  assign hold_diff = in_now_q - press_time_q;
  assign hold_eff  = press_edge ? '0 : hold_diff;
  assign held_sat  = (hold_diff > {16'd0, HeldMax}) ? HeldMax : hold_diff[MsW-1:0];

  assign long_done_eff = press_edge ? 1'b0 : long_done_q;
  assign long_fire     = settled && stable_d && !long_done_eff
                         && (hold_eff >= {16'd0, cfg.long_press_ms});

  always_comb begin
    last_raw_d   = in_raw_q;
    chg_time_d   = chg_time_eff;
    stable_d     = settled ? in_raw_q : stable_q;
    press_time_d = press_edge ? in_now_q : press_time_q;
    long_done_d  = long_done_eff || long_fire;
    if (press_edge) begin
      held_d = '0;
    end else if (release_edge) begin
      held_d = held_sat;
    end else begin
      held_d = held_q;
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      last_raw_q   <= 1'b0;
      chg_time_q   <= '0;
      stable_q     <= 1'b0;
      press_time_q <= '0;
      long_done_q  <= 1'b0;
      held_q       <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (fire) begin
        last_raw_q   <= last_raw_d;
        chg_time_q   <= chg_time_d;
        stable_q     <= stable_d;
        press_time_q <= press_time_d;
        long_done_q  <= long_done_d;
        held_q       <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_raw_q <= s_axis_tdata[0];
      in_now_q <= s_axis_tdata[32:1];
    end
    if (fire) begin
      out_data_q <= {4'd0, held_d, long_fire, release_edge, press_edge, stable_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ sv/bdlp_chk.sv @@
// Port-level checker for the button debouncer, bound to the top level.
`include "button_debounce_long_press_core_macros.svh"

module bdlp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `BDLP_ASSERT_NOW(a_press_is_pressed, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0], "press pulse while released")
  `BDLP_ASSERT_NOW(a_release_is_released, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[0], "release pulse while pressed")
  `BDLP_ASSERT_NOW(a_held_zero_pressed, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[19:4] == 16'd0, "held time nonzero while pressed")
  `BDLP_ASSERT_NOW(a_long_is_pressed, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[0], "long pulse while released")
  `BDLP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind button_debounce_long_press_core bdlp_chk u_bdlp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
